>>> hw/rtl/bmhq_pkg.sv
package bmhq_pkg;

  // heap geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = IDX_W + 1;
  localparam int DATA_W   = 32;
  localparam int STAT_W   = 2;
  localparam int HELD_W   = 5;

  // request codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                     action;
    logic signed [DATA_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] removed_value;
    logic [STAT_W-1:0]        status;
    logic [HELD_W-1:0]        entries_held;
  } out_word_t;

  // microprogram addresses, in program order
  typedef enum logic [4:0] {
    S_EMIT,
    S_IDLE,
    S_DISPATCH,
    S_INS_CHK,
    S_INS_SETUP,
    S_UP_TEST,
    S_UP_CMP,
    S_UP_MOVE,
    S_UP_PLACE,
    S_RM_ROOT,
    S_RM_LAST,
    S_RM_LOAD,
    S_DN_TEST,
    S_DN_LEFT,
    S_DN_PICK,
    S_DN_CHK,
    S_DN_MOVE,
    S_DN_PLACE,
    S_FULL,
    S_EMPTY
  } step_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_ACCEPT,
    C_IS_REMOVE,
    C_FULL,
    C_EMPTY,
    C_POS_ROOT,
    C_NOT_GREATER,
    C_NO_LEFT,
    C_BEST_IS_POS,
    C_OUT_BUSY
  } cond_e;

  // memory read address select
  typedef enum logic [2:0] {
    RD_NONE,
    RD_ZERO,
    RD_LAST,
    RD_PARENT,
    RD_LEFT,
    RD_RIGHT
  } rd_e;

  // memory write data select, always written at the current position
  typedef enum logic [1:0] {
    WR_NONE,
    WR_RDATA,
    WR_CUR,
    WR_BEST
  } wr_e;

  typedef enum logic [2:0] {
    POS_HOLD,
    POS_CNT,
    POS_ZERO,
    POS_PARENT,
    POS_BEST
  } pos_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_e;

  typedef enum logic [1:0] {
    RES_HOLD,
    RES_RDATA,
    RES_FULL,
    RES_EMPTY
  } res_e;

  // one control word per microprogram step
  typedef struct packed {
    cond_e cond;
    step_e target;
    rd_e   rd;
    wr_e   wr;
    pos_e  pos;
    cnt_e  cnt;
    res_e  res;
    logic  ld_cur;
    logic  ld_lv;
    logic  ld_best;
    logic  ld_out;
  } ctrl_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic is_remove;
    logic full;
    logic empty;
    logic pos_root;
    logic not_greater;
    logic no_left;
    logic best_is_pos;
    logic out_busy;
  } flags_t;

  // microcode rom
  function automatic ctrl_t ucode(step_e s);
    ctrl_t c;
    c = '0;
    case (s)
      S_EMIT: begin
        c.ld_out = 1'b1;
        c.cond   = C_OUT_BUSY;
        c.target = S_EMIT;
      end
      S_IDLE: begin
        c.cond   = C_NOT_ACCEPT;
        c.target = S_IDLE;
      end
      S_DISPATCH: begin
        c.cond   = C_IS_REMOVE;
        c.target = S_RM_ROOT;
      end
      S_INS_CHK: begin
        c.cond   = C_FULL;
        c.target = S_FULL;
      end
      S_INS_SETUP: begin
        c.pos = POS_CNT;
        c.cnt = CNT_INC;
      end
      S_UP_TEST: begin
        c.rd     = RD_PARENT;
        c.cond   = C_POS_ROOT;
        c.target = S_UP_PLACE;
      end
      S_UP_CMP: begin
        c.cond   = C_NOT_GREATER;
        c.target = S_UP_PLACE;
      end
      S_UP_MOVE: begin
        c.wr     = WR_RDATA;
        c.pos    = POS_PARENT;
        c.cond   = C_ALWAYS;
        c.target = S_UP_TEST;
      end
      S_UP_PLACE: begin
        c.wr     = WR_CUR;
        c.cond   = C_ALWAYS;
        c.target = S_EMIT;
      end
      S_RM_ROOT: begin
        c.rd     = RD_ZERO;
        c.cond   = C_EMPTY;
        c.target = S_EMPTY;
      end
      S_RM_LAST: begin
        c.res = RES_RDATA;
        c.rd  = RD_LAST;
        c.cnt = CNT_DEC;
        c.pos = POS_ZERO;
      end
      S_RM_LOAD: begin
        c.ld_cur = 1'b1;
      end
      S_DN_TEST: begin
        c.rd     = RD_LEFT;
        c.cond   = C_NO_LEFT;
        c.target = S_DN_PLACE;
      end
      S_DN_LEFT: begin
        c.ld_lv = 1'b1;
        c.rd    = RD_RIGHT;
      end
      S_DN_PICK: begin
        c.ld_best = 1'b1;
      end
      S_DN_CHK: begin
        c.cond   = C_BEST_IS_POS;
        c.target = S_DN_PLACE;
      end
      S_DN_MOVE: begin
        c.wr     = WR_BEST;
        c.pos    = POS_BEST;
        c.cond   = C_ALWAYS;
        c.target = S_DN_TEST;
      end
      S_DN_PLACE: begin
        c.wr     = WR_CUR;
        c.cond   = C_ALWAYS;
        c.target = S_EMIT;
      end
      S_FULL: begin
        c.res    = RES_FULL;
        c.cond   = C_ALWAYS;
        c.target = S_EMIT;
      end
      S_EMPTY: begin
        c.res    = RES_EMPTY;
        c.cond   = C_ALWAYS;
        c.target = S_EMIT;
      end
      default: begin
        c.cond   = C_ALWAYS;
        c.target = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/bmhq_seq.sv
module bmhq_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  bmhq_pkg::flags_t flags_i,
  output bmhq_pkg::ctrl_t  ctrl_o,
  output logic             in_stall_o,
  output logic             in_acc_o
);
  import bmhq_pkg::*;

  step_e step_q, step_d;
  ctrl_t uc;
  logic  jump;

  // control word and handshake for the current step
  always_comb begin
    uc         = ucode(step_q);
    ctrl_o     = uc;
    in_stall_o = (step_q != S_IDLE);
    in_acc_o   = in_valid_i && (step_q == S_IDLE);
  end

  // condition select and next step
  always_comb begin
    case (uc.cond)
      C_NEVER:       jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_NOT_ACCEPT:  jump = !in_valid_i;
      C_IS_REMOVE:   jump = flags_i.is_remove;
      C_FULL:        jump = flags_i.full;
      C_EMPTY:       jump = flags_i.empty;
      C_POS_ROOT:    jump = flags_i.pos_root;
      C_NOT_GREATER: jump = flags_i.not_greater;
      C_NO_LEFT:     jump = flags_i.no_left;
      C_BEST_IS_POS: jump = flags_i.best_is_pos;
      C_OUT_BUSY:    jump = flags_i.out_busy;
      default:       jump = 1'b1;
    endcase
    step_d = jump ? uc.target : step_e'(step_q + 5'd1);
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

>>> hw/rtl/bmhq_dp.sv
module bmhq_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bmhq_pkg::ctrl_t     ctrl_i,
  input  logic                in_acc_i,
  input  bmhq_pkg::in_word_t  in_word_i,
  input  logic                out_stall_i,
  output bmhq_pkg::flags_t    flags_o,
  output logic                out_valid_o,
  output bmhq_pkg::out_word_t out_word_o
);
  import bmhq_pkg::*;

  logic signed [DATA_W-1:0] mem_q [CAPACITY];
  logic signed [DATA_W-1:0] rdata_q;

  logic [CNT_W-1:0]         cnt_q;
  logic [IDX_W-1:0]         pos_q;
  logic signed [DATA_W-1:0] cur_q;
  logic signed [DATA_W-1:0] lv_q;
  logic signed [DATA_W-1:0] best_val_q;
  logic [IDX_W-1:0]         best_idx_q;
  logic                     best_mv_q;
  logic                     act_q;
  logic signed [DATA_W-1:0] res_q;
  logic [STAT_W-1:0]        st_q;
  logic                     out_valid_q;
  out_word_t                out_q;

  logic [IDX_W-1:0]         parent_idx;
  logic [IDX_W-1:0]         last_idx;
  logic [CNT_W-1:0]         left_idx;
  logic [CNT_W-1:0]         right_idx;
  logic [IDX_W-1:0]         rd_addr;
  logic                     rd_en;
  logic                     wr_en;
  logic signed [DATA_W-1:0] wr_data;
  logic                     l_gt;
  logic                     r_gt;
  logic signed [DATA_W-1:0] lead_val;
  logic [CNT_W-1:0]         lead_idx;
  logic signed [DATA_W-1:0] pick_val;
  logic [CNT_W-1:0]         pick_idx;
  logic                     out_busy;

  // tree addressing
  always_comb begin
    parent_idx = (pos_q - 1'b1) >> 1;
    last_idx   = IDX_W'(cnt_q - 1'b1);
    left_idx   = {pos_q, 1'b1};
    right_idx  = left_idx + 1'b1;
  end

  // read address select
  always_comb begin
    rd_en = 1'b1;
    case (ctrl_i.rd)
      RD_ZERO:   rd_addr = '0;
      RD_LAST:   rd_addr = last_idx;
      RD_PARENT: rd_addr = parent_idx;
      RD_LEFT:   rd_addr = left_idx[IDX_W-1:0];
      RD_RIGHT:  rd_addr = right_idx[IDX_W-1:0];
      default: begin
        rd_addr = '0;
        rd_en   = 1'b0;
      end
    endcase
  end

  // write data select
  always_comb begin
    wr_en = 1'b1;
    case (ctrl_i.wr)
      WR_RDATA: wr_data = rdata_q;
      WR_CUR:   wr_data = cur_q;
      WR_BEST:  wr_data = best_val_q;
      default: begin
        wr_data = cur_q;
        wr_en   = 1'b0;
      end
    endcase
  end

  // heap storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[pos_q] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // larger child pick, left wins a tie; rdata holds the right child here
  always_comb begin
    l_gt     = lv_q > cur_q;
    lead_val = l_gt ? lv_q : cur_q;
    lead_idx = l_gt ? left_idx : {1'b0, pos_q};
    r_gt     = (right_idx < cnt_q) && (rdata_q > lead_val);
    pick_val = r_gt ? rdata_q : lead_val;
    pick_idx = r_gt ? right_idx : lead_idx;
  end

  // flags for the sequencer
  always_comb begin
    out_busy             = out_valid_q && out_stall_i;
    flags_o.is_remove    = (act_q == ACT_REMOVE);
    flags_o.full         = (cnt_q == CNT_W'(CAPACITY));
    flags_o.empty        = (cnt_q == '0);
    flags_o.pos_root     = (pos_q == '0);
    flags_o.not_greater  = !(cur_q > rdata_q);
    flags_o.no_left      = (left_idx >= cnt_q);
    flags_o.best_is_pos  = !best_mv_q;
    flags_o.out_busy     = out_busy;
  end

  // entry count and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (ctrl_i.cnt)
        CNT_INC:  cnt_q <= cnt_q + 1'b1;
        CNT_DEC:  cnt_q <= cnt_q - 1'b1;
        default:  cnt_q <= cnt_q;
      endcase
      if (ctrl_i.ld_out && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (ctrl_i.pos)
      POS_CNT:    pos_q <= cnt_q[IDX_W-1:0];
      POS_ZERO:   pos_q <= '0;
      POS_PARENT: pos_q <= parent_idx;
      POS_BEST:   pos_q <= best_idx_q;
      default:    pos_q <= pos_q;
    endcase
    if (in_acc_i) begin
      act_q <= in_word_i.action;
      cur_q <= in_word_i.value;
      res_q <= '0;
      st_q  <= STATUS_OK;
    end else begin
      if (ctrl_i.ld_cur) begin
        cur_q <= rdata_q;
      end
      case (ctrl_i.res)
        RES_RDATA: res_q <= rdata_q;
        RES_FULL:  st_q  <= STATUS_FULL;
        RES_EMPTY: begin
          res_q <= '1;
          st_q  <= STATUS_EMPTY;
        end
        default: begin
          res_q <= res_q;
        end
      endcase
    end
    if (ctrl_i.ld_lv) begin
      lv_q <= rdata_q;
    end
    if (ctrl_i.ld_best) begin
      best_val_q <= pick_val;
      best_idx_q <= pick_idx[IDX_W-1:0];
      best_mv_q  <= (pick_idx != {1'b0, pos_q});
    end
    if (ctrl_i.ld_out && !out_busy) begin
      out_q.removed_value <= res_q;
      out_q.status        <= st_q;
      out_q.entries_held  <= HELD_W'(cnt_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

>>> hw/rtl/binary_max_heap_queue_unit.sv
// channel  direction  handshake             word
// in       input      in_valid_i/in_stall_o    action, value
// out      output     out_valid_o/out_stall_i  removed_value, status, entries_held
//
// one word at a time; a microprogram steps once per clock over a single-port heap store
// insert steps: take, dispatch, full check, setup, per level parent test, compare and move,
// place; remove: take, dispatch, root read, last read, load, per level child test, left load,
// pick, check and move, place; a refused insert or empty remove goes to its status step; all
// end in the emit step; a finished word waits in the output register, the next word is taken
// meanwhile; reset empties the heap at once, no clearing pass; store contents need no reset
module binary_max_heap_queue_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  bmhq_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bmhq_pkg::out_word_t out_word_o
);
  import bmhq_pkg::*;

  ctrl_t  ctrl;
  flags_t flags;
  logic   in_acc;

  // microprogram sequencer
  bmhq_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .flags_i    (flags),
    .ctrl_o     (ctrl),
    .in_stall_o (in_stall_o),
    .in_acc_o   (in_acc)
  );

  // heap datapath
  bmhq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_acc_i    (in_acc),
    .in_word_i   (in_word_i),
    .out_stall_i (out_stall_i),
    .flags_o     (flags),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

endmodule

>>> hw/rtl/bmhq_checker.sv
module bmhq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input bmhq_pkg::in_word_t  in_word_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input bmhq_pkg::out_word_t out_word_o
);
  import bmhq_pkg::*;

  // empty remove reports the marker value and an empty heap
  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status == STATUS_EMPTY) |->
      (out_word_o.removed_value == '1 && out_word_o.entries_held == '0))
    else $error("empty remove word malformed");

  // refused insert only when the heap holds its full capacity
  a_full_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status == STATUS_FULL) |->
      (out_word_o.removed_value == '0 && out_word_o.entries_held == HELD_W'(CAPACITY)))
    else $error("full insert word malformed");

  // block is busy right after taking a word
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken twice in a row");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_word_o)))
    else $error("stalled output word changed");

  // stalled request word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(in_word_i)))
    else $error("stalled input word changed");

endmodule

bind binary_max_heap_queue_unit bmhq_checker u_bmhq_checker (.*);

>>> tb/sv/tb_binary_max_heap_queue_unit.sv
`timescale 1ns / 100ps

module tb_binary_max_heap_queue_unit;
  import bmhq_pkg::*;

  localparam int RUN_LIMIT   = 400000;
  localparam int TAIL_CYCLES = 100;
  localparam int PHASE_WORDS = 240;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  // shadow heap used for prediction
  logic signed [DATA_W-1:0] shadow_heap [CAPACITY];
  int                       shadow_size;

  in_word_t  req_words [$];
  out_word_t due_words [$];

  int          mismatches;
  int unsigned cycle_cnt;
  int          in_gap_max;
  int          out_stall_max;
  int          gap_left;
  int          stall_left;
  logic        stall_armed;
  logic        in_took;
  logic        out_took;

  binary_max_heap_queue_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // apply one request to the shadow heap and return the word it should produce
  function automatic out_word_t heap_apply(in_word_t w);
    out_word_t                r;
    int                       pos;
    int                       up;
    int                       best;
    int                       lc;
    int                       rc;
    logic signed [DATA_W-1:0] t;
    r.removed_value = '0;
    r.status        = STATUS_OK;
    if (w.action == ACT_INSERT) begin
      if (shadow_size >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        // place at the tail, then sift up while strictly greater than the parent
        pos = shadow_size;
        shadow_heap[pos] = w.value;
        shadow_size++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (shadow_heap[pos] <= shadow_heap[up]) break;
          t = shadow_heap[pos];
          shadow_heap[pos] = shadow_heap[up];
          shadow_heap[up] = t;
          pos = up;
        end
      end
    end else if (shadow_size == 0) begin
      r.status        = STATUS_EMPTY;
      r.removed_value = -1;
    end else begin
      // take the root, move the tail up and sift down; left child wins ties
      r.removed_value = shadow_heap[0];
      shadow_heap[0] = shadow_heap[shadow_size - 1];
      shadow_size--;
      pos = 0;
      while (pos < shadow_size) begin
        best = pos;
        lc   = 2 * pos + 1;
        rc   = 2 * pos + 2;
        if (lc < shadow_size && shadow_heap[lc] > shadow_heap[best]) best = lc;
        if (rc < shadow_size && shadow_heap[rc] > shadow_heap[best]) best = rc;
        if (best == pos) break;
        t = shadow_heap[pos];
        shadow_heap[pos] = shadow_heap[best];
        shadow_heap[best] = t;
        pos = best;
      end
    end
    r.entries_held = HELD_W'(shadow_size);
    return r;
  endfunction

  // input side: present queued words, random gap after each accepted one
  always @(negedge clk_i) begin : driver
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (gap_left > 0 || req_words.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        in_word_i  <= req_words.pop_front();
        in_valid_i <= 1'b1;
        gap_left = $urandom_range(0, in_gap_max);
      end
    end
  end

  // output side: random stall per presented word, some stray stall while idle
  always @(negedge clk_i) begin : receiver
    if (out_took) stall_armed = 1'b0;
    if (out_valid_o === 1'b1 && !stall_armed) begin
      stall_left  = $urandom_range(0, out_stall_max);
      stall_armed = 1'b1;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (out_valid_o !== 1'b1 && out_stall_max > 0) begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor: predict on accepted input, check accepted output, watch the clock count
  always @(posedge clk_i) begin : monitor
    out_word_t want;
    if (!rst_ni) begin
      in_took  <= 1'b0;
      out_took <= 1'b0;
    end else begin
      cycle_cnt++;
      in_took  <= in_valid_i && !in_stall_o;
      out_took <= out_valid_o && !out_stall_i;
      if (in_valid_i && !in_stall_o) due_words.push_back(heap_apply(in_word_i));
      if (out_valid_o && !out_stall_i) begin
        if (due_words.size() == 0) begin
          $display("%0t: unexpected word, none expected, got %h", $time, out_word_o);
          mismatches++;
        end else begin
          want = due_words.pop_front();
          if (out_word_o.removed_value !== want.removed_value) begin
            $display("%0t: removed_value expected %0d got %0d", $time,
                     want.removed_value, out_word_o.removed_value);
            mismatches++;
          end
          if (out_word_o.status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time,
                     want.status, out_word_o.status);
            mismatches++;
          end
          if (out_word_o.entries_held !== want.entries_held) begin
            $display("%0t: entries_held expected %0d got %0d", $time,
                     want.entries_held, out_word_o.entries_held);
            mismatches++;
          end
        end
      end
      if (cycle_cnt >= RUN_LIMIT) begin
        $display("%0t: timeout with %0d words outstanding", $time, due_words.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic queue_word(logic act, logic signed [DATA_W-1:0] val);
    in_word_t w;
    w.action = act;
    w.value  = val;
    req_words.push_back(w);
  endtask

  // hold the sender until every expected word has come back
  task automatic drain_wait();
    while (req_words.size() != 0 || in_valid_i || due_words.size() != 0)
      @(posedge clk_i);
  endtask

  // random value: full width, a narrow band with many repeats, or an extreme
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 3))
      0, 1: v = $urandom;
      2: v = $signed($urandom_range(0, 8)) - 4;
      default: begin
        case ($urandom_range(0, 3))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7fff_ffff;
          2: v = 0;
          default: v = -1;
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int ph;
    int k;
    int p_ins;
    int gap_set [6];
    int stall_set [6];
    gap_set   = '{0, 10, 0, 10, 3, 0};
    stall_set = '{0, 0, 10, 10, 3, 0};

    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_word_i     = '0;
    out_stall_i   = 1'b0;
    mismatches    = 0;
    cycle_cnt     = 0;
    shadow_size   = 0;
    in_gap_max    = 0;
    out_stall_max = 0;
    gap_left      = 0;
    stall_left    = 0;
    stall_armed   = 1'b0;
    in_took       = 1'b0;
    out_took      = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: empty remove, fill with extremes and repeats, refused insert, drain part
    queue_word(ACT_REMOVE, 32'sh1234_5678);
    queue_word(ACT_INSERT, 32'sh7fff_ffff);
    queue_word(ACT_INSERT, 32'sh8000_0000);
    queue_word(ACT_INSERT, 0);
    queue_word(ACT_INSERT, -1);
    queue_word(ACT_INSERT, 1);
    queue_word(ACT_INSERT, 5);
    queue_word(ACT_INSERT, 5);
    queue_word(ACT_INSERT, 5);
    queue_word(ACT_INSERT, -5);
    queue_word(ACT_INSERT, 32'sh5555_5555);
    queue_word(ACT_INSERT, 32'shaaaa_aaaa);
    queue_word(ACT_INSERT, 32'sh7fff_fffe);
    queue_word(ACT_INSERT, 32'sh8000_0001);
    queue_word(ACT_INSERT, 5);
    queue_word(ACT_INSERT, 2);
    queue_word(ACT_INSERT, 3);
    queue_word(ACT_INSERT, 32'sh7fff_ffff);
    for (k = 0; k < 6; k++) queue_word(ACT_REMOVE, 32'shffff_ffff);
    drain_wait();

    // random phases with different idling on each side, drained in between
    for (ph = 0; ph < 6; ph++) begin
      in_gap_max    = gap_set[ph];
      out_stall_max = stall_set[ph];
      p_ins         = 50;
      for (k = 0; k < PHASE_WORDS; k++) begin
        // bias is redrawn every 16 words so the heap swings between full and empty
        if (k % 16 == 0) begin
          case ($urandom_range(0, 2))
            0: p_ins = 85;
            1: p_ins = 50;
            default: p_ins = 15;
          endcase
        end
        queue_word(($urandom_range(0, 99) < p_ins) ? ACT_INSERT : ACT_REMOVE, pick_value());
      end
      drain_wait();
    end

    out_stall_max = 0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && due_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
